>>> rtl/core/bdac_pkg.sv
package bdac_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned NUM_DIGITS = 20;
    localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
    localparam int unsigned CHAR_W     = 6;
    localparam int unsigned STEP_W     = $clog2(VALUE_W);
    localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);

    // '0' is 6'b110000, so a digit character is the digit under this prefix
    localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic skip;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic step_last;
        logic top_zero;
        logic rem_one;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/bdac_dp.sv
module bdac_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bdac_pkg::dp_cmd_t              cmd,
    output bdac_pkg::dp_stat_t             stat,
    input  logic [bdac_pkg::VALUE_W-1:0]   value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bdac_pkg::CHAR_W-1:0]    digit_char,
    output logic                           last_digit
);
    import bdac_pkg::*;

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [STEP_W-1:0]  step_cnt_reg, step_cnt_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;

    // add-3 correction on every BCD digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // shift register and counter updates
    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        step_cnt_next  = step_cnt_reg;
        rem_next       = rem_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            bin_next      = value;
            bcd_next      = '0;
            step_cnt_next = '0;
            rem_next      = REM_W'(NUM_DIGITS);
        end
        else if (cmd.step)
        begin
            bcd_next      = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next      = {bin_reg[VALUE_W-2:0], 1'b0};
            step_cnt_next = step_cnt_reg + 1'b1;
        end
        else if (cmd.skip)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
            rem_next = rem_reg - 1'b1;
        end
        else if (cmd.emit)
        begin
            char_next      = {ASCII_ZERO_HI, bcd_reg[BCD_W-1 -: 4]};
            last_next      = (rem_reg == REM_W'(1));
            bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
            rem_next       = rem_reg - 1'b1;
            out_valid_next = 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.step_last = (step_cnt_reg == {STEP_W{1'b1}});
    assign stat.top_zero  = (bcd_reg[BCD_W-1 -: 4] == 4'd0);
    assign stat.rem_one   = (rem_reg == REM_W'(1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

endmodule

>>> rtl/core/bdac_ctrl.sv
module bdac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bdac_pkg::dp_stat_t   stat,
    output bdac_pkg::dp_cmd_t    cmd
);
    import bdac_pkg::*;

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.step = 1'b1;
                if (stat.step_last)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if (stat.top_zero && !stat.rem_one)
                    cmd.skip = 1'b1;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.rem_one)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/binary_to_decimal_ascii_unit.sv
// Channel  | Handshake            | Word
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_ready  | value[63:0], unsigned binary
// output   | out_valid / out_ready| digit_char[5:0], last_digit (ends a run)
//
// One word in gives 1 to 20 digit words, most significant first.
// Conversion: a load, one double dabble shift-add step per input bit, then the
// leading zero digits are dropped (up to 19) and the remaining digits are
// emitted; dropped plus emitted digits are always 20.
// Output stalls hold the digit register; the next input word is taken once the
// last digit sits in the output register. Reset clears all control state.
module binary_to_decimal_ascii_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bdac_pkg::VALUE_W-1:0]   value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bdac_pkg::CHAR_W-1:0]    digit_char,
    output logic                           last_digit
);
    import bdac_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bdac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdac_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

>>> rtl/core/bdac_checker.sv
module bdac_sva (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] digit_char,
    input logic       last_digit
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit))
        else $error("output word changed under stall");

    // every output word is an ASCII decimal digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_char[5:4] == 2'b11 && digit_char[3:0] <= 4'd9)
        else $error("digit_char not in '0'..'9'");

    // a run does not break: a taken inner digit is followed at once by the next
    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_digit |=> out_valid)
        else $error("gap inside a digit run");

    // the input is still closed at the last shift step of the conversion after a word is taken
    a_busy_convert: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##64 !in_ready)
        else $error("input reopened during conversion");

endmodule

bind binary_to_decimal_ascii_unit bdac_sva u_bdac_sva (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last_digit (last_digit)
);
